[rtl/core/cpsh_pkg.sv]
// Shared types, widths and helpers for the capsule point and segment hit test.
package cpsh_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COORD_EFF   = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  localparam int MW      = 67;
  localparam int PW      = 2 * MW;
  localparam int WW      = 68;
  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = 33;
  localparam int QBITS   = 32;

  typedef enum logic [1:0] {
    MODE_MID,
    MODE_BOT,
    MODE_TOP
  } mode_t;

  typedef enum logic [1:0] {
    CS_START,
    CS_END,
    CS_MID
  } case_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [32:0] ux;
    logic signed [32:0] uy;
    logic signed [32:0] uz;
    logic signed [32:0] wz;
    logic signed [33:0] rm;
    mode_t              md;
  } item_t;

  typedef struct packed {
    logic signed [WW-1:0] m;
    logic signed [WW-1:0] np;
    logic signed [WW-1:0] aa;
    logic signed [WW-1:0] d;
    case_t                cs;
  } wide_t;

  function automatic logic signed [31:0] sext(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = (i < COORD_EFF) ? v[i] : v[COORD_EFF-1];
    end
    return $signed(r);
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = (v < 0) ? -v : v;
    return t[31:0];
  endfunction

  function automatic logic [63:0] satadd(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] t;
    t = {1'b0, x} + {1'b0, y};
    return t[64] ? '1 : t[63:0];
  endfunction

endpackage

[rtl/core/capsule_point_segment_hit_test.sv]
// Top level of the capsule point and segment hit test pipeline.
//
//  channel  direction  transfer when          payload
//  s_*      in         s_tvalid & s_tready    query (op in tuser, coordinates in tdata)
//  m_*      out        m_tvalid & m_tready    hit and squared distance
//  wr_*     in         wr_en                  half_length (0), radius (1)
//
// One query enters every cycle while the output is not stalled.
// The depth is set by the 33-stage fraction divider and two rounds of 4-stage multipliers.
// A stall at the output holds every stage at once; nothing is dropped or repeated.
// Reset clears the valid bits and both registers.
module capsule_point_segment_hit_test (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, margin
  input  logic [0:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // hit, dist_sq, zero pad
  input  logic         wr_en,
  input  logic [0:0]   wr_index,
  input  logic [30:0]  wr_data
);

  localparam int ST_MODE = 14;
  localparam int ST_DIV  = ST_MODE + cpsh_pkg::DIV_LAT;
  localparam int ST_CL   = 51;
  localparam int LAST    = 55;
  localparam logic [0:0] REG_HALF = 1'b0;
  localparam logic [0:0] REG_RAD  = 1'b1;

  logic [30:0] half_length, radius;
  logic [LAST:1] vld;
  logic en;

  logic               op1;
  logic signed [31:0] ax1, ay1, az1, bx1, by1, bz1, mg1;

  cpsh_pkg::item_t c [2:ST_CL];
  cpsh_pkg::wide_t wd [8:13];

  logic signed [cpsh_pkg::PW-1:0] pxx, pyy, pzz, pxa, pya, pzw;
  logic signed [cpsh_pkg::PW-1:0] pmw, puzn, plu, plm;
  logic signed [cpsh_pkg::WW-1:0] m7, p7, aa7, d7;
  logic signed [cpsh_pkg::PW-1:0] zn13, lz13;
  logic signed [cpsh_pkg::WW-1:0] numb13, negd13, num14, den14;
  logic signed [cpsh_pkg::MW-1:0] len_w;
  logic [cpsh_pkg::QBITS:0] sq47;
  logic [64:0] prx48, pry48, prz48;
  logic signed [31:0] px49, py49, pz49, px50, py50, pz50, zq50, hs;
  logic [31:0] mx51, my51, mz51;
  logic [63:0] sx52, sy52, sz52, rmsq52, s53, sz53, rmsq53, dist54, rmsq54;
  logic rmpos52, rmpos53, rmpos54;
  logic out_hit;
  logic [63:0] out_dist;
  cpsh_pkg::mode_t md_next;
  cpsh_pkg::item_t c_mode;
  logic signed [cpsh_pkg::WW-1:0] num_next, den_next;

  assign en       = !vld[LAST] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAST];
  assign m_tdata  = {7'd0, out_dist, out_hit};
  assign len_w    = $signed({{(cpsh_pkg::MW-32){1'b0}}, half_length, 1'b0});
  assign hs       = $signed({1'b0, half_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= '0;
      radius      <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HALF: half_length <= wr_data;
        REG_RAD:  radius      <= wr_data;
        default:  radius      <= radius;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], s_tvalid};
    end
  end

  always_comb begin
    c_mode    = c[ST_MODE-1];
    c_mode.md = md_next;
  end

  // entry and difference stages
  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_tuser[0];
      ax1 <= cpsh_pkg::sext(s_tdata[31:0]);
      ay1 <= cpsh_pkg::sext(s_tdata[63:32]);
      az1 <= cpsh_pkg::sext(s_tdata[95:64]);
      bx1 <= cpsh_pkg::sext(s_tdata[127:96]);
      by1 <= cpsh_pkg::sext(s_tdata[159:128]);
      bz1 <= cpsh_pkg::sext(s_tdata[191:160]);
      mg1 <= cpsh_pkg::sext(s_tdata[223:192]);
      c[2].op <= op1;
      c[2].ax <= ax1;
      c[2].ay <= ay1;
      c[2].az <= az1;
      c[2].ux <= 33'(bx1) - 33'(ax1);
      c[2].uy <= 33'(by1) - 33'(ay1);
      c[2].uz <= 33'(bz1) - 33'(az1);
      c[2].wz <= 33'(az1) + $signed({2'b00, half_length});
      c[2].rm <= 34'(mg1) + $signed({3'b000, radius});
      c[2].md <= cpsh_pkg::MODE_MID;
      for (int k = 3; k <= ST_CL; k++) begin
        c[k] <= (k == ST_MODE) ? c_mode : c[k-1];
      end
    end
  end

  cpsh_mul u_mxx (.clk, .en, .a(67'(c[2].ux)), .b(67'(c[2].ux)), .p(pxx));
  cpsh_mul u_myy (.clk, .en, .a(67'(c[2].uy)), .b(67'(c[2].uy)), .p(pyy));
  cpsh_mul u_mzz (.clk, .en, .a(67'(c[2].uz)), .b(67'(c[2].uz)), .p(pzz));
  cpsh_mul u_mxa (.clk, .en, .a(67'(c[2].ux)), .b(67'(c[2].ax)), .p(pxa));
  cpsh_mul u_mya (.clk, .en, .a(67'(c[2].uy)), .b(67'(c[2].ay)), .p(pya));
  cpsh_mul u_mzw (.clk, .en, .a(67'(c[2].uz)), .b(67'(c[2].wz)), .p(pzw));

  // dot products and case split
  always_ff @(posedge clk) begin
    if (en) begin
      m7  <= cpsh_pkg::WW'(pxx) + cpsh_pkg::WW'(pyy);
      p7  <= cpsh_pkg::WW'(pxa) + cpsh_pkg::WW'(pya);
      aa7 <= cpsh_pkg::WW'(pxx) + cpsh_pkg::WW'(pyy) + cpsh_pkg::WW'(pzz);
      d7  <= cpsh_pkg::WW'(pxa) + cpsh_pkg::WW'(pya) + cpsh_pkg::WW'(pzw);
      wd[8].m  <= m7;
      wd[8].np <= -p7;
      wd[8].aa <= aa7;
      wd[8].d  <= d7;
      if (m7 == 0 || p7 > 0) begin
        wd[8].cs <= cpsh_pkg::CS_START;
      end else if ((m7 + p7) < 0) begin
        wd[8].cs <= cpsh_pkg::CS_END;
      end else begin
        wd[8].cs <= cpsh_pkg::CS_MID;
      end
      for (int k = 9; k <= 13; k++) begin
        wd[k] <= wd[k-1];
      end
    end
  end

  cpsh_mul u_mmw (.clk, .en, .a(67'(wd[8].m)), .b(67'(c[8].wz)), .p(pmw));
  cpsh_mul u_mun (.clk, .en, .a(67'(c[8].uz)), .b(67'(wd[8].np)), .p(puzn));
  cpsh_mul u_mlu (.clk, .en, .a(len_w), .b(67'(c[8].uz)), .p(plu));
  cpsh_mul u_mlm (.clk, .en, .a(len_w), .b(67'(wd[8].m)), .p(plm));

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (wd[12].cs)
        cpsh_pkg::CS_MID: begin
          zn13 <= pmw + puzn;
          lz13 <= plm;
        end
        cpsh_pkg::CS_END: begin
          zn13 <= cpsh_pkg::PW'(c[12].wz) + cpsh_pkg::PW'(c[12].uz);
          lz13 <= cpsh_pkg::PW'(len_w);
        end
        default: begin
          zn13 <= cpsh_pkg::PW'(c[12].wz);
          lz13 <= cpsh_pkg::PW'(len_w);
        end
      endcase
      numb13 <= cpsh_pkg::WW'(plu) - wd[12].d;
      negd13 <= -wd[12].d;
    end
  end

  // axis end selection and divider operands
  always_comb begin
    md_next  = cpsh_pkg::MODE_MID;
    num_next = '0;
    den_next = cpsh_pkg::WW'(1);
    priority if (!c[13].op || half_length == '0) begin
      md_next = cpsh_pkg::MODE_MID;
    end else if (zn13 < 0) begin
      md_next  = cpsh_pkg::MODE_BOT;
      num_next = negd13;
      den_next = wd[13].aa;
    end else if (lz13 < zn13) begin
      md_next  = cpsh_pkg::MODE_TOP;
      num_next = numb13;
      den_next = wd[13].aa;
    end else begin
      unique case (wd[13].cs)
        cpsh_pkg::CS_MID: begin
          num_next = wd[13].np;
          den_next = wd[13].m;
        end
        cpsh_pkg::CS_END: num_next = cpsh_pkg::WW'(1);
        default:          num_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num14 <= num_next;
      den14 <= den_next;
    end
  end

  cpsh_div u_div (.clk, .en, .num(num14), .den(den14), .s(sq47));

  // closest point, axis point and squared distance
  always_ff @(posedge clk) begin
    if (en) begin
      prx48 <= 65'(cpsh_pkg::mag33(c[ST_DIV].ux)) * 65'(sq47);
      pry48 <= 65'(cpsh_pkg::mag33(c[ST_DIV].uy)) * 65'(sq47);
      prz48 <= 65'(cpsh_pkg::mag33(c[ST_DIV].uz)) * 65'(sq47);

      px49 <= c[48].ux[32] ? 32'(34'(c[48].ax) - 34'((prx48 + 65'h80000000) >> 32))
                           : 32'(34'(c[48].ax) + 34'((prx48 + 65'h80000000) >> 32));
      py49 <= c[48].uy[32] ? 32'(34'(c[48].ay) - 34'((pry48 + 65'h80000000) >> 32))
                           : 32'(34'(c[48].ay) + 34'((pry48 + 65'h80000000) >> 32));
      pz49 <= c[48].uz[32] ? 32'(34'(c[48].az) - 34'((prz48 + 65'h80000000) >> 32))
                           : 32'(34'(c[48].az) + 34'((prz48 + 65'h80000000) >> 32));

      px50 <= px49;
      py50 <= py49;
      pz50 <= pz49;
      unique case (c[49].md)
        cpsh_pkg::MODE_BOT: zq50 <= -hs;
        cpsh_pkg::MODE_TOP: zq50 <= hs;
        default: begin
          if (pz49 < -hs) begin
            zq50 <= -hs;
          end else if (pz49 > hs) begin
            zq50 <= hs;
          end else begin
            zq50 <= pz49;
          end
        end
      endcase

      mx51 <= cpsh_pkg::mag33(33'(px50));
      my51 <= cpsh_pkg::mag33(33'(py50));
      mz51 <= cpsh_pkg::mag33(33'(pz50) - 33'(zq50));

      sx52    <= 64'(mx51) * 64'(mx51);
      sy52    <= 64'(my51) * 64'(my51);
      sz52    <= 64'(mz51) * 64'(mz51);
      rmpos52 <= c[ST_CL].rm > 0;
      rmsq52  <= (c[ST_CL].rm > 0) ? 64'(c[ST_CL].rm[31:0]) * 64'(c[ST_CL].rm[31:0]) : '0;

      s53     <= cpsh_pkg::satadd(sx52, sy52);
      sz53    <= sz52;
      rmsq53  <= rmsq52;
      rmpos53 <= rmpos52;

      dist54  <= cpsh_pkg::satadd(s53, sz53);
      rmsq54  <= rmsq53;
      rmpos54 <= rmpos53;

      out_hit  <= rmpos54 && (dist54 < rmsq54);
      out_dist <= dist54;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during a stall");

  a_last_advances: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAST-1]) |=> m_tvalid)
    else $error("item lost before the output register");

  a_end_mode_segment: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_MODE] && (c[ST_MODE].md == cpsh_pkg::MODE_BOT
                   || c[ST_MODE].md == cpsh_pkg::MODE_TOP)) |-> c[ST_MODE].op)
    else $error("axis end chosen for a point test");

endmodule

[rtl/core/cpsh_mul.sv]
// Four-stage signed multiplier built from partial products of 33 and 34 bit halves.
module cpsh_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [cpsh_pkg::MW-1:0] a,
  input  logic signed [cpsh_pkg::MW-1:0] b,
  output logic signed [cpsh_pkg::PW-1:0] p
);

  localparam int LW = 33;
  localparam int HW = cpsh_pkg::MW - LW;

  logic                      sg1, sg2, sg3;
  logic [cpsh_pkg::MW-1:0]   ma1, mb1;
  logic [2*LW-1:0]           pp_ll;
  logic [LW+HW-1:0]          pp_lh, pp_hl;
  logic [2*HW-1:0]           pp_hh;
  logic [cpsh_pkg::PW-1:0]   sum3;
  logic signed [cpsh_pkg::MW-1:0] na, nb;

  assign na = -a;
  assign nb = -b;

  always_ff @(posedge clk) begin
    if (en) begin
      sg1   <= a[cpsh_pkg::MW-1] ^ b[cpsh_pkg::MW-1];
      ma1   <= a[cpsh_pkg::MW-1] ? na : a;
      mb1   <= b[cpsh_pkg::MW-1] ? nb : b;
      sg2   <= sg1;
      pp_ll <= ma1[LW-1:0] * mb1[LW-1:0];
      pp_lh <= (LW+HW)'(ma1[LW-1:0]) * (LW+HW)'(mb1[cpsh_pkg::MW-1:LW]);
      pp_hl <= (LW+HW)'(ma1[cpsh_pkg::MW-1:LW]) * (LW+HW)'(mb1[LW-1:0]);
      pp_hh <= ma1[cpsh_pkg::MW-1:LW] * mb1[cpsh_pkg::MW-1:LW];
      sg3   <= sg2;
      sum3  <= cpsh_pkg::PW'(pp_ll)
             + (cpsh_pkg::PW'(pp_lh) << LW)
             + (cpsh_pkg::PW'(pp_hl) << LW)
             + (cpsh_pkg::PW'(pp_hh) << (2 * LW));
      p     <= sg3 ? -$signed(sum3) : $signed(sum3);
    end
  end

endmodule

[rtl/core/cpsh_div.sv]
// Pipelined restoring divider giving a clamped unsigned Q1.32 fraction, one quotient bit a stage.
module cpsh_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [cpsh_pkg::WW-1:0] num,
  input  logic signed [cpsh_pkg::WW-1:0] den,
  output logic [cpsh_pkg::QBITS:0]       s
);

  localparam int NQ = cpsh_pkg::QBITS;
  localparam int RW = cpsh_pkg::WW - 1;

  logic [RW-1:0] rr [0:NQ];
  logic [RW-1:0] dd [0:NQ];
  logic [NQ-1:0] qq [0:NQ];
  logic          zf [0:NQ];
  logic          of [0:NQ];
  logic          pre_zero, pre_one;

  assign pre_zero = (den <= 0) || (num <= 0);
  assign pre_one  = !pre_zero && (num >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= pre_zero;
      of[0] <= pre_one;
      rr[0] <= (pre_zero || pre_one) ? '0 : num[RW-1:0];
      dd[0] <= den[RW-1:0];
      qq[0] <= '0;
      for (int i = 1; i <= NQ; i++) begin
        logic [RW:0] diff;
        diff  = {rr[i-1], 1'b0} - {1'b0, dd[i-1]};
        zf[i] <= zf[i-1];
        of[i] <= of[i-1];
        dd[i] <= dd[i-1];
        if (!diff[RW]) begin
          rr[i] <= diff[RW-1:0];
          qq[i] <= {qq[i-1][NQ-2:0], 1'b1};
        end else begin
          rr[i] <= {rr[i-1][RW-2:0], 1'b0};
          qq[i] <= {qq[i-1][NQ-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (of[NQ]) begin
      s = {1'b1, {NQ{1'b0}}};
    end else if (zf[NQ]) begin
      s = '0;
    end else begin
      s = {1'b0, qq[NQ]};
    end
  end

endmodule

[test/tb_capsule_point_segment_hit_test.sv]
// Self-checking testbench for the capsule point and segment hit test.
module tb_capsule_point_segment_hit_test;

  typedef logic signed [127:0] wide_int_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] dist_sq;
  } hit_result_t;

  typedef struct {
    logic        op;
    logic [31:0] ax, ay, az, bx, by, bz, margin;
    logic        typed;
    logic        hit;
    logic [63:0] dist_sq;
  } query_row_t;

  localparam logic OP_POINT   = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;
  localparam logic [0:0] REG_HALF_LENGTH = 1'b0;
  localparam logic [0:0] REG_RADIUS      = 1'b1;
  localparam logic [31:0] CMIN  = 32'h8000_0000;
  localparam logic [31:0] CMAX  = 32'h7fff_ffff;
  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [30:0] RMAX  = 31'h7fff_ffff;
  localparam int          DRAIN = 70;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         wr_en = 1'b0;
  logic [0:0]   wr_index = '0;
  logic [30:0]  wr_data = '0;

  logic [30:0]  half_length_q = '0;
  logic [30:0]  radius_q = '0;
  hit_result_t  expected_q[$];
  int           mismatches = 0;
  bit           steady = 1'b0;

  capsule_point_segment_hit_test u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #10 clk = ~clk;

  function automatic wide_int_t axis_frac(input wide_int_t num, input wide_int_t den);
    wide_int_t q;
    if (den <= 0 || num <= 0) return '0;
    if (num >= den) return wide_int_t'(64'h1_0000_0000);
    q = (num <<< 32) / den;
    return q;
  endfunction

  function automatic wide_int_t step_along(input wide_int_t a, input wide_int_t u,
                                           input wide_int_t s);
    wide_int_t mag, off;
    mag = (u < 0) ? -u : u;
    off = (mag * s + 128'sh8000_0000) >>> 32;
    return (u < 0) ? a - off : a + off;
  endfunction

  function automatic logic [63:0] square64(input wide_int_t v);
    wide_int_t mag, p;
    mag = (v < 0) ? -v : v;
    p = mag * mag;
    return p[63:0];
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] t;
    t = {1'b0, x} + {1'b0, y};
    return t[64] ? '1 : t[63:0];
  endfunction

  function automatic wide_int_t zclamp(input wide_int_t z, input wide_int_t h);
    return (z < -h) ? -h : ((z > h) ? h : z);
  endfunction

  function automatic hit_result_t capsule_distance(input query_row_t q);
    wide_int_t ax, ay, az, bx, by, bz, rm, h, px, py, pz, zq;
    wide_int_t ux, uy, uz, wz, len, m, p, aa, d, np, zn, zd, s, rsq;
    cpsh_pkg::mode_t md;
    hit_result_t r;
    ax = $signed(q.ax); ay = $signed(q.ay); az = $signed(q.az);
    bx = $signed(q.bx); by = $signed(q.by); bz = $signed(q.bz);
    h  = {97'b0, half_length_q};
    rm = $signed({97'b0, radius_q}) + $signed(q.margin);
    px = ax; py = ay; pz = az;
    if (q.op == OP_POINT) begin
      zq = zclamp(az, h);
    end else begin
      ux = bx - ax; uy = by - ay; uz = bz - az;
      wz = az + h; len = 2 * h;
      s = '0;
      md = cpsh_pkg::MODE_MID;
      if (len != 0) begin
        m  = ux * ux + uy * uy;
        p  = ux * ax + uy * ay;
        aa = m + uz * uz;
        d  = p + uz * wz;
        np = -p;
        if (m == 0 || np < 0) begin
          s = '0; zn = wz; zd = 1;
        end else if (m < np) begin
          s = wide_int_t'(64'h1_0000_0000); zn = wz + uz; zd = 1;
        end else begin
          s = axis_frac(np, m); zn = m * wz + uz * np; zd = m;
        end
        if (zn < 0) begin
          md = cpsh_pkg::MODE_BOT;
          s = axis_frac(-d, aa);
        end else if (len * zd < zn) begin
          md = cpsh_pkg::MODE_TOP;
          s = axis_frac(len * uz - d, aa);
        end
      end
      px = step_along(ax, ux, s);
      py = step_along(ay, uy, s);
      pz = step_along(az, uz, s);
      case (md)
        cpsh_pkg::MODE_BOT: zq = -h;
        cpsh_pkg::MODE_TOP: zq = h;
        default:            zq = zclamp(pz, h);
      endcase
    end
    r.dist_sq = sat_sum(sat_sum(square64(px), square64(py)), square64(pz - zq));
    rsq = rm * rm;
    r.hit = (rm > 0) && (r.dist_sq < rsq[63:0]);
    return r;
  endfunction

  task automatic write_reg(input logic [0:0] idx, input logic [30:0] val);
    @(posedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_HALF_LENGTH) half_length_q = val;
    else radius_q = val;
  endtask

  task automatic send_query(input query_row_t q);
    hit_result_t e;
    while (!steady && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= q.op;
    s_tdata  <= {q.margin, q.bz, q.by, q.bx, q.az, q.ay, q.ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (q.typed) begin
      e.hit = q.hit; e.dist_sq = q.dist_sq;
    end else begin
      e = capsule_distance(q);
    end
    expected_q.push_back(e);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return CMIN;
          1: return CMAX;
          2: return '0;
          default: return '1;
        endcase
      end
      2: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom_range(20 * ONE) - 10 * ONE;
    endcase
  endfunction

  function automatic query_row_t random_query();
    query_row_t q;
    q.op = 1'($urandom_range(1));
    q.ax = pick_coord(); q.ay = pick_coord(); q.az = pick_coord();
    q.bx = pick_coord(); q.by = pick_coord(); q.bz = pick_coord();
    if ($urandom_range(3) == 0) q.margin = $urandom;
    else q.margin = $urandom_range(6 * ONE) - 3 * ONE;
    q.typed = 1'b0; q.hit = 1'b0; q.dist_sq = '0;
    return q;
  endfunction

  function automatic query_row_t row(input logic op,
                                     input logic [31:0] ax, ay, az, bx, by, bz, mg,
                                     input logic typed, input logic hit,
                                     input logic [63:0] dist_val);
    query_row_t q;
    q.op = op; q.ax = ax; q.ay = ay; q.az = az; q.bx = bx; q.by = by; q.bz = bz;
    q.margin = mg; q.typed = typed; q.hit = hit; q.dist_sq = dist_val;
    return q;
  endfunction

  always @(posedge clk) begin
    hit_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b dist_sq=%h",
                                       m_tdata[0], m_tdata[64:1]);
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[0] !== e.hit || m_tdata[64:1] !== e.dist_sq) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b dist_sq=%h, got hit=%0b dist_sq=%h",
                     e.hit, e.dist_sq, m_tdata[0], m_tdata[64:1]);
        end
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 37);
  end

  initial begin
    query_row_t dir[$];
    logic [30:0] hl_set[6];
    logic [30:0] rad_set[6];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: zero-length axis, zero radius
    dir.push_back(row(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 64'h0));
    dir.push_back(row(OP_POINT, 1, 0, 0, CMAX, CMIN, 5, 2, 1, 1, 64'h1));
    dir.push_back(row(OP_POINT, CMIN, 0, 0, 0, 0, 0, CMAX, 1, 0, 64'h4000_0000_0000_0000));
    dir.push_back(row(OP_POINT, CMIN, CMIN, CMIN, 0, 0, 0, CMIN, 1, 0,
                      64'hc000_0000_0000_0000));
    dir.push_back(row(OP_SEGMENT, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, 0, 0, 0));
    foreach (dir[i]) send_query(dir[i]);
    drain_results();

    write_reg(REG_HALF_LENGTH, 31'(2 * ONE));
    write_reg(REG_RADIUS, 31'(ONE));
    dir.delete();
    dir.push_back(row(OP_POINT, 0, 0, 32'(5 * ONE), 0, 0, 0, 0, 1, 0, 64'h9_0000_0000));
    dir.push_back(row(OP_POINT, 0, 0, 32'(-5 * ONE), 0, 0, 0, 0, 1, 0, 64'h9_0000_0000));
    dir.push_back(row(OP_POINT, 32'(ONE / 2), 0, 0, 0, 0, 0, 0, 1, 1, 64'h4000_0000));
    dir.push_back(row(OP_POINT, 0, 0, 0, 0, 0, 0, 32'(-2 * ONE), 1, 0, 64'h0));
    dir.push_back(row(OP_SEGMENT, 32'(3 * ONE), 0, 0, 32'(3 * ONE), 0, 0, 0, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, 32'(3 * ONE), 0, 32'(-9 * ONE), 32'(3 * ONE), 0,
                      32'(9 * ONE), 0, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, 32'(-3 * ONE), ONE, 0, 32'(3 * ONE), ONE, ONE, 0,
                      0, 0, 0));
    dir.push_back(row(OP_SEGMENT, 32'(-3 * ONE), 0, 32'(5 * ONE), 32'(3 * ONE), 0,
                      32'(7 * ONE), 0, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, 32'(-3 * ONE), 0, 32'(-5 * ONE), 32'(3 * ONE), 0,
                      32'(-7 * ONE), 0, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, ONE, ONE, 0, 32'(4 * ONE), 32'(4 * ONE), 0, 0, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, 0, 0, 0));
    dir.push_back(row(OP_SEGMENT, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0, 0, 0));
    foreach (dir[i]) send_query(dir[i]);
    drain_results();

    hl_set  = '{RMAX, 31'(3 * ONE), 31'h0, 31'h1, 31'(ONE), 31'(5 * ONE)};
    rad_set = '{RMAX, 31'(ONE), 31'(2 * ONE), 31'h0, 31'h0, RMAX};
    foreach (hl_set[p]) begin
      if (p == 5) begin
        hl_set[p] = 31'($urandom); rad_set[p] = 31'($urandom);
      end
      write_reg(REG_HALF_LENGTH, hl_set[p]);
      write_reg(REG_RADIUS, rad_set[p]);
      for (int n = 0; n < 205; n++) begin
        steady = (p == 2 && n >= 40 && n < 160);
        send_query(random_query());
      end
      steady = 1'b0;
      drain_results();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
